/* rtl/core/jsu_pkg.sv */
`default_nettype none
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5
  } mode_e;

  // All result beats caused by one input byte. cnt is 1 to 3.
  typedef struct packed {
    logic [1:0] cnt;
    logic       mal;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } job_t;

  // Bit 4 is set when the byte is a hex digit; bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/json_string_unescape_top.sv */
`default_nettype none
// Channel   | Direction | tdata              | tlast          | tuser
// s_axis    | in        | [7:0] in_byte      | end_of_string  | -
// m_axis    | out       | [7:0] out_byte     | last_of_run    | malformed
//
// The front decodes one byte per cycle and queues the beats it causes as one job.
// The back drains jobs one beat per cycle through an output register while
// m_axis_tready_i is high, so a \u escape that yields three bytes gives three beats.
// A four-entry job queue lets the front keep accepting while the back stalls;
// s_axis_tready_o drops only when the queue is full.
// Reset clears the decoder to normal mode and empties the queue and output.
module json_string_unescape_top import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // [7:0] out_byte
  output logic            m_axis_tlast_o,
  output logic            m_axis_tuser_o   // [0] malformed
);

  logic acc, push, full, pop, head_valid;
  job_t job, head;

  assign s_axis_tready_o = !full;
  assign acc = s_axis_tvalid_i && !full;

  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (s_axis_tdata_i),
    .eos_i  (s_axis_tlast_i),
    .push_o (push),
    .job_o  (job)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (head_valid)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .tvalid_o     (m_axis_tvalid_o),
    .tready_i     (m_axis_tready_i),
    .tdata_o      (m_axis_tdata_o),
    .tlast_o      (m_axis_tlast_o),
    .tuser_o      (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

/* rtl/core/jsu_front.sv */
`default_nettype none
module jsu_front import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eos_i,
  output logic            push_o,
  output job_t            job_o
);

  mode_e       mode_q, mode_d;
  logic [11:0] acc_q, acc_d;
  logic [4:0]  hv;
  logic [15:0] v;
  logic        bad;
  job_t        job;
  logic        emit;

  assign hv = hex_nibble(byte_i);
  assign v  = {acc_q, hv[3:0]};

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    bad    = 1'b0;
    emit   = 1'b0;
    job    = '0;
    job.cnt = 2'd1;
    if (acc_i) begin
      case (mode_q)
        MODE_ESC: begin
          mode_d = MODE_NORMAL;
          emit   = 1'b1;
          case (byte_i)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: job.b0 = byte_i;
            CH_B: job.b0 = CTL_BS;
            CH_F: job.b0 = CTL_FF;
            CH_N: job.b0 = CTL_LF;
            CH_R: job.b0 = CTL_CR;
            CH_T: job.b0 = CTL_HT;
            CH_U: begin
              emit   = 1'b0;
              mode_d = MODE_HEX1;
              acc_d  = '0;
            end
            default: emit = 1'b0;
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!hv[4]) begin
            bad    = 1'b1;
            mode_d = MODE_NORMAL;
            acc_d  = '0;
          end else if (mode_q == MODE_HEX4) begin
            emit   = 1'b1;
            mode_d = MODE_NORMAL;
            acc_d  = '0;
            if (v < 16'h0080) begin
              job.b0 = v[7:0];
            end else if (v < 16'h0800) begin
              job.cnt = 2'd2;
              job.b0  = {3'b110, v[10:6]};
              job.b1  = {2'b10, v[5:0]};
            end else begin
              job.cnt = 2'd3;
              job.b0  = {4'b1110, v[15:12]};
              job.b1  = {2'b10, v[11:6]};
              job.b2  = {2'b10, v[5:0]};
            end
          end else begin
            acc_d = {acc_q[7:0], hv[3:0]};
            case (mode_q)
              MODE_HEX1: mode_d = MODE_HEX2;
              MODE_HEX2: mode_d = MODE_HEX3;
              default:   mode_d = MODE_HEX4;
            endcase
          end
        end
        default: begin
          if (byte_i == CH_BACKSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            emit   = 1'b1;
            job.b0 = byte_i;
          end
        end
      endcase
      // An escape still open at the end of the string is reported as malformed.
      if (eos_i && mode_d != MODE_NORMAL) begin
        bad = 1'b1;
      end
      if (bad) begin
        job     = '0;
        job.cnt = 2'd1;
        job.mal = 1'b1;
      end
      if (eos_i) begin
        mode_d = MODE_NORMAL;
        acc_d  = '0;
      end
    end
  end

  assign push_o = acc_i & (emit | bad);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && eos_i |=> mode_q == MODE_NORMAL && acc_q == '0)
    else $error("decoder state not cleared after end of string");

  a_mal_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.mal |-> job_o.cnt == 2'd1 && job_o.b0 == 8'd0)
    else $error("malformed job must be a single zero beat");

endmodule
`default_nettype wire

/* rtl/core/jsu_queue.sv */
`default_nettype none
module jsu_queue import jsu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  job_t       push_job_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output job_t       head_o,
  output logic       valid_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

/* rtl/core/jsu_back.sv */
`default_nettype none
module jsu_back import jsu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  job_t       head_i,
  input  wire logic  head_valid_i,
  output logic       pop_o,
  output logic       tvalid_o,
  input  wire logic  tready_i,
  output logic [7:0] tdata_o,
  output logic       tlast_o,
  output logic       tuser_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q;
  logic [7:0] data_q;
  logic       last_q, mal_q;
  logic       load, last;
  logic [7:0] beat;

  always_comb begin
    case (idx_q)
      2'd0:    beat = head_i.b0;
      2'd1:    beat = head_i.b1;
      default: beat = head_i.b2;
    endcase
  end

  assign last  = (idx_q == head_i.cnt - 2'd1);
  assign load  = head_valid_i && (!vld_q || tready_i);
  assign pop_o = load && last;
  assign idx_d = load ? (last ? 2'd0 : idx_q + 2'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        vld_q <= 1'b1;
      end else if (tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= beat;
      last_q <= last;
      mal_q  <= head_i.mal;
    end
  end

  assign tvalid_o = vld_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;
  assign tuser_o  = mal_q;

  a_mal_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tvalid_o && tuser_o |-> tlast_o && tdata_o == 8'd0)
    else $error("malformed beat must be a lone zero byte");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         drain_first;
  } raw_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       mal;
  } decoded_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;

  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;

  raw_beat_t     raw_q[$];
  decoded_beat_t decoded_q[$];
  bit            drain_next = 1'b0;

  // Decoder state as seen by the predictor.
  mode_e         dec_mode = MODE_NORMAL;
  logic [15:0]   hex_acc = 16'h0000;

  int unsigned   raw_sent = 0;
  int unsigned   decoded_seen = 0;
  int unsigned   mismatch_cnt = 0;

  always #10 clk_i = ~clk_i;

  json_string_unescape_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic int hex_digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    if ($urandom_range(1) == 0) return 8'("a") + 8'(nib - 4'd10);
    return 8'("A") + 8'(nib - 4'd10);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U};
  endfunction

  function automatic logic [7:0] simple_letter(input int k);
    case (k)
      0: return CH_QUOTE;
      1: return CH_BACKSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  task automatic push_raw(input logic [7:0] b, input logic eos);
    raw_beat_t r;
    r.b = b;
    r.eos = eos;
    r.drain_first = drain_next;
    drain_next = 1'b0;
    raw_q = {raw_q, r};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_raw(s[i], i == s.len() - 1);
    end
  endtask

  // Works out the decoded beats of one accepted raw byte and queues them.
  task automatic decode_byte(input logic [7:0] c, input logic eos);
    logic [7:0]  obuf [3];
    int          n;
    int          hv;
    logic        bad;
    logic [15:0] v;
    decoded_beat_t bt;
    n = 0;
    bad = 1'b0;
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_NORMAL;
        case (c)
          CH_QUOTE, CH_BACKSLASH, CH_SLASH: begin
            obuf[0] = c;
            n = 1;
          end
          CH_B: begin
            obuf[0] = CTL_BS;
            n = 1;
          end
          CH_F: begin
            obuf[0] = CTL_FF;
            n = 1;
          end
          CH_N: begin
            obuf[0] = CTL_LF;
            n = 1;
          end
          CH_R: begin
            obuf[0] = CTL_CR;
            n = 1;
          end
          CH_T: begin
            obuf[0] = CTL_HT;
            n = 1;
          end
          CH_U: begin
            dec_mode = MODE_HEX1;
            hex_acc = 16'h0000;
          end
          default: ;
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        hv = hex_digit_val(c);
        if (hv < 0) begin
          bad = 1'b1;
          dec_mode = MODE_NORMAL;
          hex_acc = 16'h0000;
        end else begin
          hex_acc = {hex_acc[11:0], 4'(hv)};
          if (dec_mode == MODE_HEX4) begin
            v = hex_acc;
            if (v < 16'h0080) begin
              obuf[0] = v[7:0];
              n = 1;
            end else if (v < 16'h0800) begin
              obuf[0] = {3'b110, v[10:6]};
              obuf[1] = {2'b10, v[5:0]};
              n = 2;
            end else begin
              obuf[0] = {4'b1110, v[15:12]};
              obuf[1] = {2'b10, v[11:6]};
              obuf[2] = {2'b10, v[5:0]};
              n = 3;
            end
            dec_mode = MODE_NORMAL;
            hex_acc = 16'h0000;
          end else begin
            dec_mode = mode_e'(dec_mode + 3'd1);
          end
        end
      end
      default: begin
        if (c == CH_BACKSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          obuf[0] = c;
          n = 1;
        end
      end
    endcase
    // An escape still open at the end of the string is reported as malformed.
    if (eos && dec_mode != MODE_NORMAL) bad = 1'b1;
    if (bad) begin
      obuf[0] = 8'h00;
      n = 1;
    end
    if (eos) begin
      dec_mode = MODE_NORMAL;
      hex_acc = 16'h0000;
    end
    for (int i = 0; i < n; i++) begin
      bt.data = obuf[i];
      bt.last = (i == n - 1);
      bt.mal = bad;
      decoded_q = {decoded_q, bt};
    end
  endtask

  // Driver: presents raw bytes from raw_q and predicts each accepted beat.
  always @(posedge clk_i) begin : raw_driver
    raw_beat_t nxt;
    bit        give;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        decode_byte(s_tdata, s_tlast);
        raw_sent++;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        give = 1'b0;
        if (raw_q.size() != 0) begin
          give = 1'b1;
          if (raw_q[0].drain_first && decoded_q.size() != 0) give = 1'b0;
          if ((raw_sent < 120 || raw_sent >= 220) && $urandom_range(99) < 30) give = 1'b0;
        end
        if (give) begin
          nxt = raw_q.pop_front();
          s_tdata <= nxt.b;
          s_tlast <= nxt.eos;
        end
        s_tvalid <= give;
      end
    end
  end

  // Monitor: checks every accepted output beat against the oldest prediction.
  always @(posedge clk_i) begin : decoded_monitor
    decoded_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) begin
        decoded_seen++;
        if (decoded_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] unexpected beat: byte=%02h last=%0b mal=%0b", $realtime,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          end
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata_o !== want.data || m_axis_tlast_o !== want.last ||
              m_axis_tuser_o !== want.mal) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] beat %0d: exp %02h/%0b/%0b got %02h/%0b/%0b",
                       $realtime, decoded_seen, want.data, want.last, want.mal,
                       m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
            end
          end
        end
      end
      m_tready <= !((decoded_seen < 100 || decoded_seen >= 200) && $urandom_range(99) < 30);
    end
  end

  initial begin : stimulus
    logic [7:0]  txt[$];
    logic [7:0]  b;
    logic [15:0] v;
    int          nseg;
    int          kind;
    int          k;
    bit          mid_drain_done;
    mid_drain_done = 1'b0;

    // Directed strings: raw extremes, one simple escape, the three UTF-8
    // lengths, an unknown letter, a bad hex digit and a dangling backslash.
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b1);
    push_text("\\n");
    push_text("\\u0000");
    push_text("\\u07FF");
    push_text("\\uFFFF");
    push_text("\\q");
    push_text("\\uG");
    push_text("\\");

    drain_next = 1'b1;
    while (raw_q.size() < 290) begin
      if (!mid_drain_done && raw_q.size() >= 180) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      txt.delete();
      nseg = $urandom_range(1, 8);
      for (int s = 0; s < nseg; s++) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          b = 8'($urandom_range(255));
          if (b == CH_BACKSLASH) b = 8'h41;
          txt = {txt, b};
        end else if (kind < 55) begin
          txt = {txt, CH_BACKSLASH};
          txt = {txt, simple_letter($urandom_range(7))};
        end else if (kind < 80) begin
          case ($urandom_range(2))
            0: v = 16'($urandom_range(16'h007F));
            1: v = 16'($urandom_range(16'h07FF, 16'h0080));
            default: v = 16'($urandom_range(16'hFFFF, 16'h0800));
          endcase
          txt = {txt, CH_BACKSLASH};
          txt = {txt, CH_U};
          for (int d = 3; d >= 0; d--) txt = {txt, hex_char(v[d*4 +: 4])};
        end else if (kind < 88) begin
          do b = 8'($urandom_range(255)); while (is_escape_letter(b));
          txt = {txt, CH_BACKSLASH};
          txt = {txt, b};
        end else if (kind < 95) begin
          txt = {txt, CH_BACKSLASH};
          txt = {txt, CH_U};
          k = $urandom_range(3);
          for (int d = 0; d < k; d++) txt = {txt, hex_char(4'($urandom_range(15)))};
          do b = 8'($urandom_range(255)); while (hex_digit_val(b) >= 0);
          txt = {txt, b};
        end else begin
          txt = {txt, 8'($urandom_range(255))};
        end
      end
      // Now and then the string ends in the middle of an escape.
      if ($urandom_range(9) == 0) begin
        txt = {txt, CH_BACKSLASH};
        if ($urandom_range(1) == 1) begin
          txt = {txt, CH_U};
          k = $urandom_range(3);
          for (int d = 0; d < k; d++) txt = {txt, hex_char(4'($urandom_range(15)))};
        end
      end
      for (int i = 0; i < txt.size(); i++) push_raw(txt[i], i == txt.size() - 1);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("** json_string_unescape_top: PASSED **");
    end else begin
      $display("** json_string_unescape_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("** json_string_unescape_top: FAILED **");
    $finish;
  end

endmodule
